### hw/rtl/bwsd_pkg.sv
package bwsd_pkg;

    // Default block capacity in texels.
    localparam int MAX_TEXELS_DEF = 256;

    // Field widths.
    localparam int CHAN_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int OUT_W    = 16;
    localparam int SUM_W    = 24;

    // Shared multiplier: 40 x 24 operands, 64-bit product.
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = 64;

    // Accumulated error over a full block, divisor n^3 * 66049, remainder and quotient.
    localparam int ACC_W = 72;
    localparam int DEN_W = 41;
    localparam int REM_W = DEN_W + 1;
    localparam int QUO_W = 34;

    // Configuration port.
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ALPHA = 8'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd16384;

    // 257 squared: scales UNORM16 deviations to 0..255 units.
    localparam logic [MUL_B_W-1:0] SCALE_SQ = 24'd66049;

    // One texel, channel 0 is red, channel 3 is alpha.
    typedef logic [3:0][CHAN_W-1:0] texel_t;

    // Request to the divide and square root unit.
    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] numer;
        logic [DEN_W-1:0] denom;
    } root_req_t;

    // Response from the divide and square root unit.
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] root;
    } root_rsp_t;

endpackage

### hw/rtl/block_weighted_std_dev.sv
// Weighted max-channel standard deviation of one texture block.
//
// Texels enter on the s_ channel (valid/ready), one per cycle while the block
// loads; s_last closes the block. Up to MAX_TEXELS texels are kept, later ones
// are dropped but their last flag still closes the block. After the closing
// item the input is held off while one shared 40x24 multiplier walks the
// stored texels: the divisor first, then each texel in turn (one memory read,
// five steps per channel, one accumulate). A divide unit and then a square
// root follow; a constant block skips them all and gives 0. The result
// waits in an output register on the m_ channel; loading of the next block
// resumes at once, and only the next closing block waits for that register
// to drain if the receiver stalls. Weights are written on the cfg_ channel
// (always ready); they must be written only while idle, which the block
// does not enforce. Reset empties the block, drops any pending result and
// sets all weights to 0.25. The texel memory needs no clearing.
module block_weighted_std_dev
    import bwsd_pkg::*;
#(
    parameter int MAX_TEXELS = MAX_TEXELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAN_W-1:0]    s_red,
    input  logic [CHAN_W-1:0]    s_green,
    input  logic [CHAN_W-1:0]    s_blue,
    input  logic [CHAN_W-1:0]    s_alpha,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_std_dev,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_TEXELS + 1);
    localparam int IDX_W = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_D1   = 4'd1;
    localparam logic [3:0] S_D2   = 4'd2;
    localparam logic [3:0] S_D3   = 4'd3;
    localparam logic [3:0] S_D4   = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_X    = 4'd6;
    localparam logic [3:0] S_DEV  = 4'd7;
    localparam logic [3:0] S_W    = 4'd8;
    localparam logic [3:0] S_E    = 4'd9;
    localparam logic [3:0] S_CMP  = 4'd10;
    localparam logic [3:0] S_ACC  = 4'd11;
    localparam logic [3:0] S_ROOT = 4'd12;
    localparam logic [3:0] S_WAIT = 4'd13;
    localparam logic [3:0] S_EMIT = 4'd14;

    logic [3:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        eq_reg, eq_next;
    logic [3:0][SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [1:0]                  chan_reg, chan_next;
    logic                        m_valid_reg, m_valid_next;
    logic [3:0][WEIGHT_W-1:0]    weight_reg;

    texel_t                      first_reg;
    texel_t                      rd_data_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [SUM_W-1:0]            dev_reg;
    logic [PROD_W-1:0]           best_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic [DEN_W-1:0]            den_reg;
    logic [OUT_W-1:0]            result_reg;
    logic [OUT_W-1:0]            m_data_reg;

    texel_t                      texel_mem [MAX_TEXELS];

    texel_t                      s_texel;
    logic                        in_acc;
    logic                        room;
    logic                        mismatch;
    logic                        eq_after;
    logic                        emit_go;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic [SUM_W-1:0]            xn;
    logic [SUM_W-1:0]            sum_sel;
    root_req_t                   root_req;
    root_rsp_t                   root_rsp;

    // Input side decode.
    always_comb begin
        s_texel  = {s_alpha, s_blue, s_green, s_red};
        in_acc   = s_valid && (state_reg == S_LOAD);
        room     = count_reg < CNT_W'(MAX_TEXELS);
        mismatch = (count_reg != '0) && (s_texel != first_reg);
        eq_after = eq_reg && !(room && mismatch);
        emit_go  = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    end

    assign s_ready   = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_std_dev = m_data_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_D1: begin
                mul_a = MUL_A_W'(count_reg);
                mul_b = MUL_B_W'(count_reg);
            end
            S_D2: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(count_reg);
            end
            S_D3: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = SCALE_SQ;
            end
            S_X: begin
                mul_a = MUL_A_W'(rd_data_reg[chan_reg]);
                mul_b = MUL_B_W'(count_reg);
            end
            S_W: begin
                mul_a = MUL_A_W'(dev_reg);
                mul_b = MUL_B_W'(weight_reg[chan_reg]);
            end
            S_E: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = dev_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        xn      = prod_reg[SUM_W-1:0];
        sum_sel = sum_reg[chan_reg];
    end

    // Sequencer: load, divisor, per-texel error walk, root, result hand-off.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        eq_next      = eq_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        chan_next    = chan_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        count_next = count_reg + 1'b1;
                        eq_next    = eq_after;
                        for (int c = 0; c < 4; c++) begin
                            sum_next[c] = sum_reg[c] + SUM_W'(s_texel[c]);
                        end
                    end
                    if (s_last) begin
                        state_next = eq_after ? S_EMIT : S_D1;
                    end
                end
            end
            S_D1: state_next = S_D2;
            S_D2: state_next = S_D3;
            S_D3: state_next = S_D4;
            S_D4: begin
                idx_next   = '0;
                state_next = S_RD;
            end
            S_RD: begin
                chan_next  = '0;
                state_next = S_X;
            end
            S_X:   state_next = S_DEV;
            S_DEV: state_next = S_W;
            S_W:   state_next = S_E;
            S_E:   state_next = S_CMP;
            S_CMP: begin
                if (chan_reg == 2'd3) begin
                    state_next = S_ACC;
                end else begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_X;
                end
            end
            S_ACC: begin
                if (idx_reg + 1'b1 == count_reg) begin
                    state_next = S_ROOT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_ROOT: state_next = S_WAIT;
            S_WAIT: begin
                if (root_rsp.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    eq_next      = 1'b1;
                    sum_next     = '0;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            eq_reg      <= 1'b1;
            sum_reg     <= '0;
            idx_reg     <= '0;
            chan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            eq_reg      <= eq_next;
            sum_reg     <= sum_next;
            idx_reg     <= idx_next;
            chan_reg    <= chan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Channel weights.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= {4{WEIGHT_RESET}};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WEIGHT_RED:   weight_reg[0] <= cfg_data;
                REG_WEIGHT_GREEN: weight_reg[1] <= cfg_data;
                REG_WEIGHT_BLUE:  weight_reg[2] <= cfg_data;
                REG_WEIGHT_ALPHA: weight_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Texel memory: one write port for loading, one registered read port for the walk.
    always_ff @(posedge aclk) begin
        if (in_acc && room) begin
            texel_mem[count_reg[IDX_W-1:0]] <= s_texel;
        end
        rd_data_reg <= texel_mem[idx_reg[IDX_W-1:0]];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (in_acc && room && (count_reg == '0)) begin
            first_reg <= s_texel;
        end
        if (state_reg == S_DEV) begin
            dev_reg <= (xn >= sum_sel) ? (xn - sum_sel) : (sum_sel - xn);
        end
        if (state_reg == S_D4) begin
            den_reg <= prod_reg[DEN_W-1:0];
            acc_reg <= '0;
        end
        if (state_reg == S_RD) begin
            best_reg <= '0;
        end else if ((state_reg == S_CMP) && (prod_reg > best_reg)) begin
            best_reg <= prod_reg;
        end
        if (state_reg == S_ACC) begin
            acc_reg <= acc_reg + ACC_W'(best_reg);
        end
        if (in_acc && s_last && eq_after) begin
            result_reg <= '0;
        end else if ((state_reg == S_WAIT) && root_rsp.done) begin
            result_reg <= root_rsp.root;
        end
        if (emit_go) begin
            m_data_reg <= result_reg;
        end
    end

    // Divide by n^3 * 66049, then square root.
    assign root_req.start = (state_reg == S_ROOT);
    assign root_req.numer = acc_reg;
    assign root_req.denom = den_reg;

    bwsd_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (root_req),
        .rsp     (root_rsp)
    );

endmodule

### hw/rtl/bwsd_root.sv
module bwsd_root
    import bwsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  root_req_t req,
    output root_rsp_t rsp
);

    localparam int STEP_W = $clog2(ACC_W);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_DIV  = 2'd1;
    localparam logic [1:0] R_SQRT = 2'd2;
    localparam logic [1:0] R_DONE = 2'd3;

    localparam logic [QUO_W-1:0] BIT_TOP = {2'b01, {(QUO_W-2){1'b0}}};

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ACC_W-1:0]  numer_reg, numer_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [QUO_W-1:0]  res_reg, res_next;
    logic [QUO_W-1:0]  bit_reg, bit_next;

    logic [REM_W-1:0]  rem_shift;
    logic              rem_ge;
    logic [QUO_W:0]    trial;
    logic              sq_ge;

    // One restoring divide step and one square root step.
    always_comb begin
        rem_shift = {rem_reg[REM_W-2:0], numer_reg[ACC_W-1]};
        rem_ge    = rem_shift >= {1'b0, den_reg};
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        sq_ge     = {1'b0, quo_reg} >= trial;
    end

    // Sequencer: a quotient bit per cycle, then a root bit per cycle.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        numer_next = numer_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        case (state_reg)
            R_IDLE: begin
                if (req.start) begin
                    numer_next = req.numer;
                    den_next   = req.denom;
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = STEP_W'(ACC_W - 1);
                    state_next = R_DIV;
                end
            end
            R_DIV: begin
                numer_next = {numer_reg[ACC_W-2:0], 1'b0};
                rem_next   = rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
                quo_next   = {quo_reg[QUO_W-2:0], rem_ge};
                step_next  = step_reg - 1'b1;
                if (step_reg == '0) begin
                    res_next   = '0;
                    bit_next   = BIT_TOP;
                    step_next  = STEP_W'(QUO_W / 2 - 1);
                    state_next = R_SQRT;
                end
            end
            R_SQRT: begin
                if (sq_ge) begin
                    quo_next = quo_reg - trial[QUO_W-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = R_DONE;
                end
            end
            R_DONE: begin
                state_next = R_IDLE;
            end
            default: begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
        end else begin
            state_reg <= state_next;
        end
        step_reg  <= step_next;
        numer_reg <= numer_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
    end

    // The root fits 16 bits for every legal input; saturate all the same.
    assign rsp.done = (state_reg == R_DONE);
    assign rsp.root = (|res_reg[QUO_W-1:OUT_W]) ? {OUT_W{1'b1}} : res_reg[OUT_W-1:0];

endmodule

### hw/rtl/bwsd_checker.sv
module bwsd_checker
    import bwsd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_last,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_std_dev
);

    // Leaving reset, the block is empty and ready for texels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (s_ready && !m_valid))
        else $error("block not empty after reset");

    // The input is only held off after a closing item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_last))
        else $error("input stalled without a closing item");

    // A closing item always stops loading in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input still ready after a closing item");

    // A new result only appears while the input is held off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while loading");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_std_dev)))
        else $error("stalled result changed");

endmodule

bind block_weighted_std_dev bwsd_checker u_bwsd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_last    (s_last),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_std_dev (m_std_dev)
);

### bench/block_weighted_std_dev_tb.sv
`timescale 1ns / 1ps

module block_weighted_std_dev_tb;
    import bwsd_pkg::*;

    localparam int          MAX_KEPT      = MAX_TEXELS_DEF;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          STALL_LIMIT   = 40000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          RANDOM_ITEMS  = 1100;

    // Register indexes that address no weight and must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    localparam logic [CHAN_W-1:0]    CHAN_MIN = '0;
    localparam logic [CHAN_W-1:0]    CHAN_MAX = '1;

    // Shapes of the texel content of one block.
    typedef enum int {
        PAT_RANDOM,
        PAT_FLAT,
        PAT_ONE_OFF,
        PAT_RAILS,
        PAT_NEAR
    } pattern_e;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [CHAN_W-1:0]    s_red     = '0;
    logic [CHAN_W-1:0]    s_green   = '0;
    logic [CHAN_W-1:0]    s_blue    = '0;
    logic [CHAN_W-1:0]    s_alpha   = '0;
    logic                 s_last    = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [OUT_W-1:0]     m_std_dev;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WEIGHT_W-1:0]  cfg_data  = '0;

    // Predictor state: the texels of the open block and the current weights.
    texel_t               texel_mem [MAX_KEPT];
    logic [SUM_W-1:0]     chan_sum  [4];
    int unsigned          kept;
    texel_t               first_tx;
    bit                   flat;
    logic [WEIGHT_W-1:0]  weight    [4];

    logic [OUT_W-1:0]     std_dev_q [$];
    int unsigned          mismatch_count;
    int unsigned          texels_sent;
    int unsigned          quiet_cycles;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;

    block_weighted_std_dev u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_red     (s_red),
        .s_green   (s_green),
        .s_blue    (s_blue),
        .s_alpha   (s_alpha),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_std_dev (m_std_dev),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Spread of the closed block: largest weighted squared deviation per texel,
    // averaged and square-rooted, all in exact integer arithmetic.
    function automatic logic [OUT_W-1:0] block_spread();
        logic [127:0] total;
        logic [127:0] quot;
        logic [63:0]  n;
        logic [63:0]  xn;
        logic [63:0]  dev;
        logic [63:0]  err;
        logic [63:0]  best;
        logic [63:0]  root;
        logic [63:0]  cand;
        total = '0;
        n     = 64'(kept);
        if (flat || kept == 0) return '0;
        for (int unsigned i = 0; i < kept; i++) begin
            best = '0;
            for (int c = 0; c < 4; c++) begin
                xn  = 64'(texel_mem[i][c]) * n;
                dev = (xn >= 64'(chan_sum[c])) ? xn - 64'(chan_sum[c])
                                               : 64'(chan_sum[c]) - xn;
                err = dev * dev * 64'(weight[c]);
                if (err > best) best = err;
            end
            total += 128'(best);
        end
        quot = total / (128'(n) * 128'(n) * 128'(n) * 128'(SCALE_SQ));
        root = '0;
        for (int b = 20; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= quot) root = cand;
        end
        return (root > 64'hFFFF) ? '1 : root[OUT_W-1:0];
    endfunction

    // Takes one accepted texel into the open block; a closing texel queues
    // the expected spread and empties the block.
    function automatic void absorb_texel(input texel_t t, input logic lst);
        if (kept < MAX_KEPT) begin
            if (kept == 0) first_tx = t;
            else if (t != first_tx) flat = 1'b0;
            texel_mem[kept] = t;
            for (int c = 0; c < 4; c++) chan_sum[c] += SUM_W'(t[c]);
            kept++;
        end
        if (lst) begin
            std_dev_q.push_back(block_spread());
            for (int c = 0; c < 4; c++) chan_sum[c] = '0;
            kept = 0;
            flat = 1'b1;
        end
    endfunction

    function automatic texel_t rand_texel();
        texel_t t;
        for (int c = 0; c < 4; c++) t[c] = CHAN_W'($urandom());
        return t;
    endfunction

    function automatic texel_t make_texel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                          input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
        texel_t t;
        t = {a, b, g, r};
        return t;
    endfunction

    // Result side: check each accepted result, then choose the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (std_dev_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("std_dev %0d arrived with no block closed", m_std_dev);
            end else begin
                if (m_std_dev !== std_dev_q[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("std_dev mismatch: expected %0d, got %0d",
                                 std_dev_q[0], m_std_dev);
                end
                void'(std_dev_q.pop_front());
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one texel, idling first at the phase's rate; valid stays high
    // after acceptance so that back-to-back items need no second assignment.
    task automatic send_texel(input texel_t t, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= t[0];
        s_green <= t[1];
        s_blue  <= t[2];
        s_alpha <= t[3];
        s_last  <= lst;
        do @(posedge aclk); while (!s_ready);
        absorb_texel(t, lst);
        texels_sent++;
    endtask

    // Holds the input off until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (std_dev_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_WEIGHT_ALPHA) weight[idx[1:0]] = val;
    endtask

    task automatic release_cfg();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes all four weights; the block must already be drained.
    task automatic set_weights(input logic [WEIGHT_W-1:0] wr, input logic [WEIGHT_W-1:0] wg,
                               input logic [WEIGHT_W-1:0] wb, input logic [WEIGHT_W-1:0] wa);
        write_reg(REG_WEIGHT_RED, wr);
        write_reg(REG_WEIGHT_GREEN, wg);
        write_reg(REG_WEIGHT_BLUE, wb);
        write_reg(REG_WEIGHT_ALPHA, wa);
        release_cfg();
    endtask

    // Sends one block of the given length whose texels follow a pattern.
    task automatic send_block(input int unsigned len, input pattern_e pat);
        texel_t      base;
        texel_t      t;
        int unsigned odd_idx;
        base    = rand_texel();
        odd_idx = $urandom_range(len - 1);
        for (int unsigned i = 0; i < len; i++) begin
            t = base;
            case (pat)
                PAT_RANDOM: begin
                    t = rand_texel();
                end
                PAT_ONE_OFF: begin
                    if (i == odd_idx) t[2'($urandom_range(3))] = CHAN_W'($urandom());
                end
                PAT_RAILS: begin
                    for (int c = 0; c < 4; c++) t[c] = $urandom_range(1) ? CHAN_MAX : CHAN_MIN;
                end
                PAT_NEAR: begin
                    for (int c = 0; c < 4; c++)
                        t[c] = base[c] + CHAN_W'($urandom_range(4)) - CHAN_W'(2);
                end
                default: begin
                end
            endcase
            send_texel(t, i == len - 1);
        end
    endtask

    // Single texels, constant blocks and full-scale swings.
    task automatic test_extremes();
        send_texel(make_texel(CHAN_MIN, CHAN_MIN, CHAN_MIN, CHAN_MIN), 1'b1);
        send_texel(make_texel(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX), 1'b1);
        send_texel(make_texel(CHAN_MIN, CHAN_MIN, CHAN_MIN, CHAN_MIN), 1'b0);
        send_texel(make_texel(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX), 1'b1);
        for (int i = 0; i < 3; i++)
            send_texel(make_texel(CHAN_MAX, CHAN_MIN, CHAN_MAX, CHAN_MIN), i == 2);
    endtask

    // Each channel alone carries the deviation, then all four differ so that
    // the largest channel changes from texel to texel.
    task automatic test_channel_selection();
        texel_t t;
        for (int c = 0; c < 4; c++) begin
            t = make_texel(16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_texel(t, 1'b0);
            t[c] = CHAN_MAX;
            send_texel(t, 1'b1);
        end
        send_texel(make_texel(16'd100, 16'd0, 16'd60000, 16'd300), 1'b0);
        send_texel(make_texel(16'd50000, 16'd10, 16'd60010, 16'd0), 1'b0);
        send_texel(make_texel(16'd100, 16'd40000, 16'd0, 16'd100), 1'b0);
        send_texel(make_texel(16'd101, 16'd10, 16'd60000, CHAN_MAX), 1'b1);
    endtask

    // Weight settings at their extremes, ignored register indexes, and
    // a return to the reset weights.
    task automatic test_weight_settings();
        wait_drained();
        set_weights('0, '0, '0, '0);
        send_block(4, PAT_RAILS);
        wait_drained();
        set_weights('1, '1, '1, '1);
        send_block(4, PAT_RAILS);
        send_block(3, PAT_RANDOM);
        wait_drained();
        set_weights('1, '0, '0, '0);
        send_block(4, PAT_RANDOM);
        wait_drained();
        set_weights('0, '0, '0, '1);
        send_block(4, PAT_RANDOM);
        wait_drained();
        write_reg(REG_UNUSED_LOW, '0);
        write_reg(REG_UNUSED_TOP, 16'h5A5A);
        release_cfg();
        send_block(4, PAT_RANDOM);
        wait_drained();
        set_weights(WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET);
    endtask

    // Blocks longer than the store: the texels past the limit are dropped,
    // the closing one among them.
    task automatic test_block_overflow();
        send_block(MAX_KEPT + 1, PAT_RANDOM);
        send_block(MAX_KEPT + 2, PAT_NEAR);
    endtask

    // Random blocks under one idling pattern, with fresh weights first.
    task automatic run_traffic_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned items);
        int unsigned goal;
        int unsigned len;
        int unsigned pick;
        int unsigned spare;
        logic [WEIGHT_W-1:0] w [4];
        pattern_e    pat;
        wait_drained();
        if ($urandom_range(1)) begin
            for (int c = 0; c < 4; c++) w[c] = WEIGHT_W'($urandom());
        end else begin
            spare = 65535;
            for (int c = 0; c < 3; c++) begin
                w[c]  = WEIGHT_W'($urandom_range(spare));
                spare = spare - w[c];
            end
            w[3] = WEIGHT_W'(spare);
        end
        set_weights(w[0], w[1], w[2], w[3]);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = texels_sent + items;
        while (texels_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(1, 8);
            else if (pick < 95) len = $urandom_range(9, 40);
            else if (pick < 99) len = $urandom_range(41, 128);
            else                len = $urandom_range(200, MAX_KEPT);
            pick = $urandom_range(99);
            if (pick < 40)      pat = PAT_RANDOM;
            else if (pick < 55) pat = PAT_FLAT;
            else if (pick < 70) pat = PAT_ONE_OFF;
            else if (pick < 85) pat = PAT_RAILS;
            else                pat = PAT_NEAR;
            send_block(len, pat);
            if ($urandom_range(24) == 0) wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, RANDOM_ITEMS / 4);
        run_traffic_phase(53, 0, RANDOM_ITEMS / 4);
        run_traffic_phase(0, 53, RANDOM_ITEMS / 4);
        run_traffic_phase(25, 25, RANDOM_ITEMS / 4);
    endtask

    initial begin
        for (int c = 0; c < 4; c++) begin
            chan_sum[c] = '0;
            weight[c]   = WEIGHT_RESET;
        end
        kept           = 0;
        flat           = 1'b1;
        first_tx       = '0;
        mismatch_count = 0;
        texels_sent    = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_channel_selection();
        test_weight_settings();
        test_block_overflow();
        test_random_traffic();

        // Let the last results through, then give the verdict.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && std_dev_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
